>>> rtl/shcc_pkg.sv
`default_nettype none

package shcc_pkg;

    // Number of sample bits that take part in the hue mapping.
    localparam int SAMPLE_BITS = 12;

    // Port widths of the payload and the configuration registers.
    localparam int ADC_W  = 12;
    localparam int FX_W   = 11;
    localparam int FRAC_W = 10;
    localparam int CHAN_W = 8;
    localparam int T_W    = ADC_W + 3;

    // Unsigned fixed point with ten fraction bits: FX_ONE stands for 1.0.
    localparam logic [FX_W-1:0] FX_ONE = FX_W'(1024);

    localparam logic [ADC_W-1:0] SAMPLE_MASK = ADC_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [T_W-1:0]   T_MASK      = T_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic [FX_W-1:0] SAT_RESET   = FX_W'(1014);
    localparam logic [FX_W-1:0] LIGHT_RESET = FX_W'(512);

    localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(255);

    typedef enum logic [0:0] {
        REG_SATURATION = 1'b0,
        REG_LIGHTNESS  = 1'b1
    } cfg_index_t;

    // Hue sectors of sixty degrees each.
    typedef enum logic [2:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5
    } sector_t;

    // Scales one channel value plus offset by 255/1024 and saturates at 255.
    function automatic logic [CHAN_W-1:0] to_channel(
        input logic [FX_W-1:0] v,
        input logic [FX_W-1:0] m
    );
        logic [FX_W:0]  sum;
        logic [19:0]    scaled;
        logic [9:0]     q;
        sum    = {1'b0, v} + {1'b0, m};
        scaled = {sum, 8'b0} - {8'b0, sum};
        q      = scaled[19:10];
        return (q > 10'(CHAN_MAX)) ? CHAN_MAX : q[CHAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/sample_to_hue_color_converter_core.sv
`default_nettype none

// Converts a stream of raw converter samples into RGB colors: each sample is
// masked to shcc_pkg::SAMPLE_BITS bits and mapped linearly onto the hue circle
// (full scale is 360 degrees), then turned into an 8-bit red, green and blue
// triple using the configured saturation and lightness (unsigned fixed point,
// 1024 means 1.0, values above 1024 act as 1024). The block takes one request
// per clock while the output side does not stall and delivers one result per
// request, in order. Each request passes through the three register stages of
// the pipeline: chroma multiply, the intermediate-value multiply with the
// offset, and the channel scaling into the output register. Stalls on the
// output side back up stage by stage, so empty stages still take new requests
// while a finished result waits. Saturation and lightness are written through
// cfg_write_en, cfg_index and cfg_data (index 0 is saturation, reset 1014;
// index 1 is lightness, reset 512) and must only be changed while no request
// is in flight.
module sample_to_hue_color_converter_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_write_en,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [shcc_pkg::FX_W-1:0]     cfg_data,

    input  wire logic                          sample_valid,
    output      logic                          sample_ready,
    input  wire logic [shcc_pkg::ADC_W-1:0]    adc_sample,

    output      logic                          rgb_valid,
    input  wire logic                          rgb_ready,
    output      logic [shcc_pkg::CHAN_W-1:0]   red,
    output      logic [shcc_pkg::CHAN_W-1:0]   green,
    output      logic [shcc_pkg::CHAN_W-1:0]   blue
);

    // Configuration registers.
    logic [shcc_pkg::FX_W-1:0] saturation_reg, saturation_next;
    logic [shcc_pkg::FX_W-1:0] lightness_reg, lightness_next;

    // Stage A: sector, fraction, chroma and clamped lightness.
    logic                          a_valid_reg, a_valid_next;
    logic [2:0]                    a_sect_reg, a_sect_next;
    logic [shcc_pkg::FRAC_W-1:0]   a_frac_reg, a_frac_next;
    logic [shcc_pkg::FX_W-1:0]     a_chroma_reg, a_chroma_next;
    logic [shcc_pkg::FX_W-1:0]     a_light_reg, a_light_next;

    // Stage B: sector, chroma, intermediate value and offset.
    logic                          b_valid_reg, b_valid_next;
    logic [2:0]                    b_sect_reg, b_sect_next;
    logic [shcc_pkg::FX_W-1:0]     b_chroma_reg, b_chroma_next;
    logic [shcc_pkg::FX_W-1:0]     b_inter_reg, b_inter_next;
    logic [shcc_pkg::FX_W-1:0]     b_offset_reg, b_offset_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [shcc_pkg::CHAN_W-1:0]   red_reg, red_next;
    logic [shcc_pkg::CHAN_W-1:0]   green_reg, green_next;
    logic [shcc_pkg::CHAN_W-1:0]   blue_reg, blue_next;

    // Each stage moves when it is empty or the stage after it moves.
    logic out_adv;
    logic b_adv;
    logic a_adv;

    assign out_adv      = !out_valid_reg || rgb_ready;
    assign b_adv        = !b_valid_reg || out_adv;
    assign a_adv        = !a_valid_reg || b_adv;
    assign sample_ready = a_adv;

    // Configuration writes.
    always_comb
    begin
        saturation_next = saturation_reg;
        lightness_next  = lightness_reg;
        if (cfg_write_en)
        begin
            unique case (shcc_pkg::cfg_index_t'(cfg_index))
                shcc_pkg::REG_SATURATION: saturation_next = cfg_data;
                shcc_pkg::REG_LIGHTNESS:  lightness_next  = cfg_data;
                default:                  saturation_next = saturation_reg;
            endcase
        end
    end

    // Stage A logic: hue split and chroma. The hue position is sample * 6;
    // the bits above the sample width are the sector and the rest, rescaled
    // to ten fraction bits, is the position within the sector.
    logic [shcc_pkg::ADC_W-1:0]    sample_m;
    logic [shcc_pkg::T_W-1:0]      hue_pos;
    logic [shcc_pkg::T_W-1:0]      hue_low;
    logic [shcc_pkg::FX_W-1:0]     sat_cl;
    logic [shcc_pkg::FX_W-1:0]     light_cl;
    logic [shcc_pkg::FX_W:0]       light_x2;
    logic [shcc_pkg::FX_W-1:0]     light_dev;
    logic [shcc_pkg::FX_W-1:0]     chroma_span;
    logic [2*shcc_pkg::FX_W-1:0]   chroma_prod;

    always_comb
    begin
        sample_m    = adc_sample & shcc_pkg::SAMPLE_MASK;
        hue_pos     = shcc_pkg::T_W'({sample_m, 2'b0}) + shcc_pkg::T_W'({sample_m, 1'b0});
        hue_low     = hue_pos & shcc_pkg::T_MASK;
        sat_cl      = (saturation_reg > shcc_pkg::FX_ONE) ? shcc_pkg::FX_ONE : saturation_reg;
        light_cl    = (lightness_reg > shcc_pkg::FX_ONE) ? shcc_pkg::FX_ONE : lightness_reg;
        light_x2    = {light_cl, 1'b0};
        // Distance of lightness from one half, in the doubled scale.
        if (light_x2 >= {1'b0, shcc_pkg::FX_ONE})
        begin
            light_dev = shcc_pkg::FX_W'(light_x2 - {1'b0, shcc_pkg::FX_ONE});
        end
        else
        begin
            light_dev = shcc_pkg::FX_W'({1'b0, shcc_pkg::FX_ONE} - light_x2);
        end
        chroma_span = shcc_pkg::FX_ONE - light_dev;
        chroma_prod = (2*shcc_pkg::FX_W)'(chroma_span) * (2*shcc_pkg::FX_W)'(sat_cl);

        a_valid_next  = a_adv ? sample_valid : a_valid_reg;
        a_sect_next   = 3'(hue_pos >> shcc_pkg::SAMPLE_BITS);
        a_frac_next   = shcc_pkg::FRAC_W'({hue_low, 10'b0} >> shcc_pkg::SAMPLE_BITS);
        a_chroma_next = shcc_pkg::FX_W'(chroma_prod >> 10);
        a_light_next  = light_cl;
    end

    // Stage B logic: intermediate value rises in even sectors and falls in
    // odd ones; the offset centers the color on the lightness.
    logic [shcc_pkg::FX_W-1:0]     inter_op;
    logic [2*shcc_pkg::FX_W-1:0]   inter_prod;
    logic [shcc_pkg::FX_W-1:0]     chroma_half;

    always_comb
    begin
        if (a_sect_reg[0])
        begin
            inter_op = shcc_pkg::FX_ONE - {1'b0, a_frac_reg};
        end
        else
        begin
            inter_op = {1'b0, a_frac_reg};
        end
        inter_prod  = (2*shcc_pkg::FX_W)'(a_chroma_reg) * (2*shcc_pkg::FX_W)'(inter_op);
        chroma_half = a_chroma_reg >> 1;

        b_valid_next  = b_adv ? a_valid_reg : b_valid_reg;
        b_sect_next   = a_sect_reg;
        b_chroma_next = a_chroma_reg;
        b_inter_next  = shcc_pkg::FX_W'(inter_prod >> 10);
        b_offset_next = (a_light_reg >= chroma_half) ? (a_light_reg - chroma_half)
                                                     : '0;
    end

    // Output stage logic: sector mix, then scaling of each channel.
    logic [shcc_pkg::FX_W-1:0] mix_r;
    logic [shcc_pkg::FX_W-1:0] mix_g;
    logic [shcc_pkg::FX_W-1:0] mix_b;

    always_comb
    begin
        unique case (shcc_pkg::sector_t'(b_sect_reg))
            shcc_pkg::SECT_RED_YELLOW:
            begin
                mix_r = b_chroma_reg; mix_g = b_inter_reg;  mix_b = '0;
            end
            shcc_pkg::SECT_YELLOW_GREEN:
            begin
                mix_r = b_inter_reg;  mix_g = b_chroma_reg; mix_b = '0;
            end
            shcc_pkg::SECT_GREEN_CYAN:
            begin
                mix_r = '0;           mix_g = b_chroma_reg; mix_b = b_inter_reg;
            end
            shcc_pkg::SECT_CYAN_BLUE:
            begin
                mix_r = '0;           mix_g = b_inter_reg;  mix_b = b_chroma_reg;
            end
            shcc_pkg::SECT_BLUE_MAGENTA:
            begin
                mix_r = b_inter_reg;  mix_g = '0;           mix_b = b_chroma_reg;
            end
            default:
            begin
                mix_r = b_chroma_reg; mix_g = '0;           mix_b = b_inter_reg;
            end
        endcase

        out_valid_next = out_adv ? b_valid_reg : out_valid_reg;
        red_next       = shcc_pkg::to_channel(mix_r, b_offset_reg);
        green_next     = shcc_pkg::to_channel(mix_g, b_offset_reg);
        blue_next      = shcc_pkg::to_channel(mix_b, b_offset_reg);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_reg <= shcc_pkg::SAT_RESET;
            lightness_reg  <= shcc_pkg::LIGHT_RESET;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            saturation_reg <= saturation_next;
            lightness_reg  <= lightness_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers load whenever their stage moves.
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_sect_reg   <= a_sect_next;
            a_frac_reg   <= a_frac_next;
            a_chroma_reg <= a_chroma_next;
            a_light_reg  <= a_light_next;
        end
        if (b_adv)
        begin
            b_sect_reg   <= b_sect_next;
            b_chroma_reg <= b_chroma_next;
            b_inter_reg  <= b_inter_next;
            b_offset_reg <= b_offset_next;
        end
        if (out_adv)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

`ifndef SYNTHESIS
    // Chroma never exceeds one.
    a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_chroma_reg <= shcc_pkg::FX_ONE))
        else $error("chroma above one in stage A");

    // The sector stays within the six hue sectors.
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_sect_reg <= 3'd5))
        else $error("hue sector out of range");

    // Intermediate value never exceeds chroma.
    b_inter_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_inter_reg <= b_chroma_reg))
        else $error("intermediate value above chroma");

    // A request in stage B that may move shows up at the output next cycle.
    b_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && out_adv) |=> rgb_valid)
        else $error("result lost between stage B and output");

    // Input backpressure only when every stage holds a request.
    full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (a_valid_reg && b_valid_reg && out_valid_reg && !rgb_ready))
        else $error("input stalled with an empty stage");
`endif

endmodule

`default_nettype wire

>>> bench/hue_rgb_checker.sv
`timescale 1ns / 1ps

module hue_rgb_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_write_en,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [shcc_pkg::FX_W-1:0]     cfg_data,

    input  wire logic                          sample_valid,
    input  wire logic                          sample_ready,
    input  wire logic [shcc_pkg::ADC_W-1:0]    adc_sample,

    input  wire logic                          rgb_valid,
    input  wire logic                          rgb_ready,
    input  wire logic [shcc_pkg::CHAN_W-1:0]   red,
    input  wire logic [shcc_pkg::CHAN_W-1:0]   green,
    input  wire logic [shcc_pkg::CHAN_W-1:0]   blue,

    output int                                 mismatch_count,
    output int                                 colors_pending
);

    localparam int UNITY = 1024;

    typedef struct packed {
        logic [shcc_pkg::ADC_W-1:0]  sample;
        logic [shcc_pkg::CHAN_W-1:0] red;
        logic [shcc_pkg::CHAN_W-1:0] green;
        logic [shcc_pkg::CHAN_W-1:0] blue;
    } color_t;

    color_t                      expected_colors[$];
    color_t                      oldest;
    logic [shcc_pkg::FX_W-1:0]   sat_copy;
    logic [shcc_pkg::FX_W-1:0]   light_copy;
    int                          errors;

    // Offset plus channel value, scaled by 255/1024 and clipped at full intensity.
    function automatic logic [shcc_pkg::CHAN_W-1:0] scale_channel(
        input logic [shcc_pkg::FX_W-1:0] level,
        input logic [shcc_pkg::FX_W-1:0] offset
    );
        logic [31:0] product;
        product = ((32'(level) + 32'(offset)) * 32'd255) >> shcc_pkg::FRAC_W;
        return (product > 32'd255) ? shcc_pkg::CHAN_W'(255)
                                   : product[shcc_pkg::CHAN_W-1:0];
    endfunction

    function automatic color_t predict_color(
        input logic [shcc_pkg::ADC_W-1:0] raw,
        input logic [shcc_pkg::FX_W-1:0]  sat_reg,
        input logic [shcc_pkg::FX_W-1:0]  light_reg
    );
        logic [shcc_pkg::ADC_W-1:0]  level;
        logic [shcc_pkg::T_W-1:0]    hue_pos;
        shcc_pkg::sector_t           sector;
        logic [shcc_pkg::FRAC_W-1:0] frac;
        logic [shcc_pkg::FX_W-1:0]   sat;
        logic [shcc_pkg::FX_W-1:0]   light;
        logic [shcc_pkg::FX_W:0]     twice;
        logic [shcc_pkg::FX_W-1:0]   spread;
        logic [shcc_pkg::FX_W-1:0]   chroma;
        logic [shcc_pkg::FX_W-1:0]   inter;
        logic [shcc_pkg::FX_W-1:0]   half;
        logic [shcc_pkg::FX_W-1:0]   offset;
        logic [shcc_pkg::FX_W-1:0]   r;
        logic [shcc_pkg::FX_W-1:0]   g;
        logic [shcc_pkg::FX_W-1:0]   b;
        logic [31:0]                 wide;
        color_t                      result;

        level   = raw & shcc_pkg::ADC_W'((32'd1 << shcc_pkg::SAMPLE_BITS) - 32'd1);
        hue_pos = shcc_pkg::T_W'(level) * shcc_pkg::T_W'(6);
        sector  = shcc_pkg::sector_t'(3'(hue_pos >> shcc_pkg::SAMPLE_BITS));
        wide    = (32'(hue_pos) & ((32'd1 << shcc_pkg::SAMPLE_BITS) - 32'd1)) * 32'(UNITY);
        frac    = shcc_pkg::FRAC_W'(wide >> shcc_pkg::SAMPLE_BITS);

        sat    = (32'(sat_reg) > UNITY) ? shcc_pkg::FX_W'(UNITY) : sat_reg;
        light  = (32'(light_reg) > UNITY) ? shcc_pkg::FX_W'(UNITY) : light_reg;
        twice  = {light, 1'b0};
        spread = (32'(twice) >= UNITY) ? shcc_pkg::FX_W'(32'(twice) - UNITY)
                                       : shcc_pkg::FX_W'(UNITY - 32'(twice));
        wide   = (32'(UNITY) - 32'(spread)) * 32'(sat);
        chroma = shcc_pkg::FX_W'(wide >> shcc_pkg::FRAC_W);

        if (sector[0] == 1'b0) begin
            wide = 32'(chroma) * 32'(frac);
        end
        else begin
            wide = 32'(chroma) * (32'(UNITY) - 32'(frac));
        end
        inter  = shcc_pkg::FX_W'(wide >> shcc_pkg::FRAC_W);
        half   = chroma >> 1;
        offset = (light >= half) ? light - half : '0;

        unique case (sector)
            shcc_pkg::SECT_RED_YELLOW:   begin r = chroma; g = inter;  b = '0;     end
            shcc_pkg::SECT_YELLOW_GREEN: begin r = inter;  g = chroma; b = '0;     end
            shcc_pkg::SECT_GREEN_CYAN:   begin r = '0;     g = chroma; b = inter;  end
            shcc_pkg::SECT_CYAN_BLUE:    begin r = '0;     g = inter;  b = chroma; end
            shcc_pkg::SECT_BLUE_MAGENTA: begin r = inter;  g = '0;     b = chroma; end
            default:                     begin r = chroma; g = '0;     b = inter;  end
        endcase

        result.sample = raw;
        result.red    = scale_channel(r, offset);
        result.green  = scale_channel(g, offset);
        result.blue   = scale_channel(b, offset);
        return result;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sat_copy   = shcc_pkg::SAT_RESET;
            light_copy = shcc_pkg::LIGHT_RESET;
            errors     = 0;
            expected_colors.delete();
            mismatch_count <= 0;
            colors_pending <= 0;
        end
        else begin
            // A request taken at this edge still sees the settings from
            // before any write at the same edge.
            if (sample_valid && sample_ready) begin
                expected_colors.push_back(predict_color(adc_sample, sat_copy, light_copy));
            end

            if (cfg_write_en) begin
                unique case (shcc_pkg::cfg_index_t'(cfg_index))
                    shcc_pkg::REG_SATURATION: sat_copy   = cfg_data;
                    shcc_pkg::REG_LIGHTNESS:  light_copy = cfg_data;
                    default:                  ;
                endcase
            end

            if (rgb_valid && rgb_ready) begin
                if (expected_colors.size() == 0) begin
                    if (errors < 10) begin
                        $display("[%0t] unexpected color r=%0d g=%0d b=%0d %s",
                                 $time, red, green, blue, "with no request open");
                    end
                    errors++;
                end
                else begin
                    oldest = expected_colors.pop_front();
                    if (red !== oldest.red || green !== oldest.green
                            || blue !== oldest.blue) begin
                        if (errors < 10) begin
                            $display({"[%0t] sample %0d: expected r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     $time, oldest.sample, oldest.red, oldest.green,
                                     oldest.blue, red, green, blue);
                        end
                        errors++;
                    end
                end
            end

            mismatch_count <= errors;
            colors_pending <= expected_colors.size();
        end
    end

endmodule

>>> bench/sample_to_hue_color_converter_core_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sample-to-hue color converter. The checker
// instance beside the block predicts every color and compares it; this module
// only produces requests, shapes back-pressure and decides the outcome.
module sample_to_hue_color_converter_core_tb;

    // Nine phases of random requests, each under its own color settings.
    localparam int PHASES          = 9;
    localparam int PHASE_REQUESTS  = 175;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int LONG_HOLD       = 120;
    localparam int CORNER_COUNT    = 18;

    // Hue corners: both ends of the range, both sides of every sector border,
    // and alternating bit patterns.
    localparam logic [shcc_pkg::ADC_W-1:0] CORNER_SAMPLES [CORNER_COUNT] = '{
        12'd0,    12'd4095, 12'd1,    12'd682,  12'd683,  12'd1365,
        12'd1366, 12'd2047, 12'd2048, 12'd2730, 12'd2731, 12'd3413,
        12'd3414, 12'd4094, 12'hAAA,  12'h555,  12'd341,  12'd3754
    };

    // Saturation and lightness per phase; the last two phases draw their own.
    localparam logic [shcc_pkg::FX_W-1:0] PHASE_SAT [7] = '{
        11'd0, 11'd1024, 11'd2047, 11'd1024, 11'd2047, 11'd512, 11'd1024
    };
    localparam logic [shcc_pkg::FX_W-1:0] PHASE_LIGHT [7] = '{
        11'd512, 11'd1024, 11'd0, 11'd512, 11'd2047, 11'd256, 11'd0
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write_en;
    logic [0:0]                      cfg_index;
    logic [shcc_pkg::FX_W-1:0]       cfg_data;
    logic                            sample_valid;
    logic                            sample_ready;
    logic [shcc_pkg::ADC_W-1:0]      adc_sample;
    logic                            rgb_valid;
    logic                            rgb_ready;
    logic [shcc_pkg::CHAN_W-1:0]     red;
    logic [shcc_pkg::CHAN_W-1:0]     green;
    logic [shcc_pkg::CHAN_W-1:0]     blue;

    int                  mismatch_count;
    int                  colors_pending;
    int                  cycle_count;

    // Idling controls shared between the request side and the result side.
    bit                  tx_idle_on;
    bit                  rx_idle_on;
    bit                  hold_requested;

    sample_to_hue_color_converter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .adc_sample   (adc_sample),
        .rgb_valid    (rgb_valid),
        .rgb_ready    (rgb_ready),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    hue_rgb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .adc_sample     (adc_sample),
        .rgb_valid      (rgb_valid),
        .rgb_ready      (rgb_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .mismatch_count (mismatch_count),
        .colors_pending (colors_pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost color ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sample_to_hue_color_converter_core verification failed");
            $finish;
        end
    end

    // Result side. Ready is decided once per edge, so it never gets two
    // assignments in one step. Short random stalls alternate with runs of accepted
    // colors. A long hold, when asked for, is counted down here so that the request
    // side keeps pushing meanwhile and the pipeline fills up until it pushes back
    // on its input.
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        rgb_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requested) begin
                hold_requested = 1'b0;
                stall_left     = LONG_HOLD;
            end
            if (stall_left > 0) begin
                rgb_ready <= 1'b0;
                stall_left--;
            end
            else begin
                rgb_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end
                else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 14);
                end
                else begin
                    run_left = $urandom_range(1, 20);
                end
            end
        end
    end

    // Samples: mostly uniform over the whole range so that every bit toggles,
    // with extra weight on the sector borders where the intermediate value
    // flips between rising and falling, and on the two ends of the range.
    function automatic logic [shcc_pkg::ADC_W-1:0] pick_sample();
        int choice;
        int border;
        choice = $urandom_range(0, 19);
        if (choice < 14) begin
            return shcc_pkg::ADC_W'($urandom_range(0, 4095));
        end
        else if (choice < 17) begin
            border = (int'($urandom_range(0, 6)) * 4096 + 5) / 6
                     + int'($urandom_range(0, 4)) - 2;
            if (border < 0) begin
                border = 0;
            end
            if (border > 4095) begin
                border = 4095;
            end
            return shcc_pkg::ADC_W'(border);
        end
        else begin
            return ($urandom_range(0, 1) == 1) ? shcc_pkg::ADC_W'(4095)
                                               : shcc_pkg::ADC_W'(0);
        end
    endfunction

    // Presents one sample request and returns right after the edge at which it
    // is taken. An optional idle burst goes in front of it. Valid stays high
    // between back-to-back requests, so it is never dropped and raised again
    // in the same step.
    task automatic offer_sample(input logic [shcc_pkg::ADC_W-1:0] value);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        adc_sample   <= value;
        do begin
            @(posedge clk);
        end while (!sample_ready);
    endtask

    // Drops valid and waits until the checker holds no open request. The
    // first edge is taken before looking, so a request accepted at the current
    // edge is already counted.
    task automatic wait_until_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (colors_pending != 0) begin
            @(posedge clk);
        end
    endtask

    // Both registers are written on consecutive edges with the enable held
    // high throughout. Only called while the pipeline is empty.
    task automatic load_color_settings(
        input logic [shcc_pkg::FX_W-1:0] sat,
        input logic [shcc_pkg::FX_W-1:0] light
    );
        cfg_write_en <= 1'b1;
        cfg_index    <= shcc_pkg::REG_SATURATION;
        cfg_data     <= sat;
        @(posedge clk);
        cfg_index    <= shcc_pkg::REG_LIGHTNESS;
        cfg_data     <= light;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial begin
        logic [shcc_pkg::FX_W-1:0] sat;
        logic [shcc_pkg::FX_W-1:0] light;

        cycle_count    = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        hold_requested = 1'b0;

        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= shcc_pkg::REG_SATURATION;
        cfg_data     <= '0;
        sample_valid <= 1'b0;
        adc_sample   <= '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners run under the reset settings.
        for (int i = 0; i < CORNER_COUNT; i++) begin
            offer_sample(CORNER_SAMPLES[i]);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // Settings only change once the last color has come out.
            wait_until_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);

            if (phase < 7) begin
                sat   = PHASE_SAT[phase];
                light = PHASE_LIGHT[phase];
            end
            else begin
                sat   = ($urandom_range(0, 1) == 1)
                        ? shcc_pkg::FX_W'($urandom_range(0, 1024))
                        : shcc_pkg::FX_W'($urandom_range(0, 2047));
                light = ($urandom_range(0, 1) == 1)
                        ? shcc_pkg::FX_W'($urandom_range(0, 1024))
                        : shcc_pkg::FX_W'($urandom_range(0, 2047));
            end
            load_color_settings(sat, light);

            // Phase two stalls the result side for a long stretch while
            // requests keep coming without gaps; phase four has no idling at
            // all, and the final phase runs at full rate on both sides.
            tx_idle_on = (phase != 2) && (phase != 4) && (phase != PHASES - 1);
            rx_idle_on = (phase != 4) && (phase != PHASES - 1);
            if (phase == 2) begin
                hold_requested = 1'b1;
            end

            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                // Halfway through phase five the request side pauses until
                // every outstanding color has been delivered.
                if (phase == 5 && i == PHASE_REQUESTS / 2) begin
                    wait_until_drained();
                end
                offer_sample(pick_sample());
            end
        end

        wait_until_drained();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && colors_pending == 0) begin
            $display("sample_to_hue_color_converter_core verification clean");
        end
        else begin
            $display("sample_to_hue_color_converter_core verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/shcc_pkg.sv
rtl/sample_to_hue_color_converter_core.sv
bench/hue_rgb_checker.sv
bench/sample_to_hue_color_converter_core_tb.sv
